[rtl/triangle_min_path_sum_defines.svh]
// Assertion macros shared by the triangle minimum path sum RTL.
`ifndef TRIANGLE_MIN_PATH_SUM_DEFINES_SVH
`define TRIANGLE_MIN_PATH_SUM_DEFINES_SVH

`ifndef SYNTHESIS

`define TMPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TMPS_ASSERT_IMP(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) trig |-> cons) else $error(msg);

`define TMPS_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) trig |=> cons) else $error(msg);

`else

`define TMPS_ASSERT(label, clk, rst, prop, msg)

`define TMPS_ASSERT_IMP(label, clk, rst, trig, cons, msg)

`define TMPS_ASSERT_NEXT(label, clk, rst, trig, cons, msg)

`endif

`endif

[rtl/tmps_pkg.sv]
// Shared types and constants of the triangle minimum path sum block.
`default_nettype none

package tmps_pkg;

  localparam int VALUE_W      = 16;
  localparam int SUM_W        = 24;
  localparam int MAX_ROWS_DEF = 256;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PARTIAL  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // one item between the scheduling stage and the update stage
  typedef struct packed {
    logic                      first_row;
    logic                      first_col;
    logic                      row_end;
    logic                      discard;
    logic                      last;
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
  } stage_t;

endpackage

`default_nettype wire

[rtl/tmps_if.sv]
// Valid/ready channels for triangle entries and path sum results.
`default_nettype none

interface tmps_entry_if import tmps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface tmps_result_if import tmps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] min_total;
  status_t                 status;

  modport source (output valid, output min_total, output status, input ready);
  modport sink (input valid, input min_total, input status, output ready);
endinterface

`default_nettype wire

[rtl/tmps_row_mem.sv]
// Row sum store: one write port, one registered read port with write bypass.
`default_nettype none

module tmps_row_mem import tmps_pkg::*; #(
  parameter int DEPTH = MAX_ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [SUM_W-1:0] wdata,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           raddr,
  output logic signed [SUM_W-1:0]      rdata
);

  logic signed [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-cycle write to the read address is forwarded
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/tmps_sched.sv]
// Entry intake: row and column counters, store read issue, stage register.
`default_nettype none
`include "triangle_min_path_sum_defines.svh"

module tmps_sched import tmps_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int CW       = $clog2(MAX_ROWS),
  parameter int RW       = $clog2(MAX_ROWS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      valid,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                      last,
  input  wire logic                      advance,
  output logic                           ready,
  output logic                           rd_en,
  output logic [CW-1:0]                  rd_addr,
  output logic                           s1_valid,
  output stage_t                         s1,
  output logic [CW-1:0]                  s1_col
);

  logic [RW-1:0] row_idx, row_idx_next;
  logic [CW-1:0] col_idx, col_idx_next;
  logic          rows_exceeded, rows_exceeded_next;
  logic          accept, over, at_end;
  stage_t        s1_next;

  assign ready   = !s1_valid || advance;
  assign accept  = valid && ready;
  assign over    = (row_idx == RW'(MAX_ROWS));
  assign at_end  = (RW'(col_idx) == row_idx);
  assign rd_en   = accept;
  assign rd_addr = col_idx;

  always_comb begin
    row_idx_next       = row_idx;
    col_idx_next       = col_idx;
    rows_exceeded_next = rows_exceeded || over;
    if (last) begin
      row_idx_next       = '0;
      col_idx_next       = '0;
      rows_exceeded_next = 1'b0;
    end else if (!over) begin
      if (at_end) begin
        row_idx_next = row_idx + RW'(1);
        col_idx_next = '0;
      end else begin
        col_idx_next = col_idx + CW'(1);
      end
    end
  end

  always_comb begin
    s1_next.first_row = (row_idx == '0);
    s1_next.first_col = (col_idx == '0);
    s1_next.row_end   = at_end;
    s1_next.discard   = over;
    s1_next.last      = last;
    s1_next.value     = value;
    if (rows_exceeded || over) begin
      s1_next.status = STATUS_OVERFLOW;
    end else if (!at_end) begin
      s1_next.status = STATUS_PARTIAL;
    end else begin
      s1_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx       <= '0;
      col_idx       <= '0;
      rows_exceeded <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        row_idx       <= row_idx_next;
        col_idx       <= col_idx_next;
        rows_exceeded <= rows_exceeded_next;
        s1_valid      <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1     <= s1_next;
      s1_col <= col_idx;
    end
  end

  `TMPS_ASSERT(a_col_le_row, clk, rst, (RW'(col_idx) <= row_idx), "column past row end")
  `TMPS_ASSERT(a_row_bound, clk, rst, (row_idx <= RW'(MAX_ROWS)), "row counter past limit")
  `TMPS_ASSERT_NEXT(a_last_clears, clk, rst, (accept && last), ((row_idx == '0) && (col_idx == '0) && !rows_exceeded), "last item did not clear counters")

endmodule

`default_nettype wire

[rtl/tmps_update.sv]
// Path sum update: parent select, saturating add, row minimum, result register.
`default_nettype none
`include "triangle_min_path_sum_defines.svh"

module tmps_update import tmps_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int CW       = $clog2(MAX_ROWS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s1_valid,
  input  wire stage_t                  s1,
  input  wire logic [CW-1:0]           s1_col,
  input  wire logic signed [SUM_W-1:0] rd_data,
  input  wire logic                    out_ready,
  output logic                         advance,
  output logic                         we,
  output logic [CW-1:0]                waddr,
  output logic signed [SUM_W-1:0]      wdata,
  output logic                         out_valid,
  output logic signed [SUM_W-1:0]      min_total,
  output status_t                      status
);

  logic signed [SUM_W-1:0] left_parent, row_min;
  logic signed [SUM_W-1:0] parent, sum, row_min_upd;
  logic signed [SUM_W:0]   sum_wide;

  assign advance = s1_valid && (!s1.last || !out_valid || out_ready);

  always_comb begin
    if (s1.first_row) begin
      parent = '0;
    end else if (s1.first_col) begin
      parent = rd_data;
    end else if (s1.row_end) begin
      parent = left_parent;
    end else begin
      parent = (rd_data < left_parent) ? rd_data : left_parent;
    end
  end

  always_comb begin
    sum_wide = {parent[SUM_W-1], parent}
             + {{(SUM_W + 1 - VALUE_W){s1.value[VALUE_W-1]}}, s1.value};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    if (s1.discard) begin
      row_min_upd = row_min;
    end else if (s1.first_col || (sum < row_min)) begin
      row_min_upd = sum;
    end else begin
      row_min_upd = row_min;
    end
  end

  assign we    = advance && !s1.discard;
  assign waddr = s1_col;
  assign wdata = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_parent <= '0;
      row_min     <= SUM_MAX;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        if (s1.last) begin
          left_parent <= '0;
          row_min     <= SUM_MAX;
        end else begin
          row_min <= row_min_upd;
          if (!s1.discard && !s1.row_end) begin
            left_parent <= rd_data;
          end
        end
      end
      if (advance && s1.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.last) begin
      min_total <= row_min_upd;
      status    <= s1.status;
    end
  end

  `TMPS_ASSERT_IMP(a_stall_needs_full, clk, rst, (s1_valid && !advance), out_valid, "stage stalled with empty result register")

endmodule

`default_nettype wire

[rtl/triangle_min_path_sum.sv]
// Top level of the triangle minimum path sum block.
//
// Usage:
//   entry  : triangle entries in row-major order (row r has r+1 entries), with
//            last set on the final entry of the triangle.
//   result : one item per triangle: minimum path sum over the final row,
//            saturated to 24 bits, and a status (ok, last row incomplete,
//            too many rows). Entries past row MAX_ROWS-1 are dropped.
//   Throughput: one entry per cycle while not stalled. Each entry does one
//   row store read at intake and one write in the update stage; a write to
//   the entry being read is forwarded in the store, so no bubble is needed.
//   Result: the last entry is registered in the stage register, and the
//   result register loads when that entry leaves the update stage.
//   Stall: the result register holds until taken; entries keep flowing
//   unless a second last entry reaches the update stage, then entry.ready
//   drops until the result is taken.
//   Reset: counters and control clear at once; the row store is not
//   cleared and needs no clearing pass. After last the block restarts clean.
`default_nettype none

module triangle_min_path_sum import tmps_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  tmps_entry_if.sink    entry,
  tmps_result_if.source result
);

  localparam int CW = $clog2(MAX_ROWS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic                    advance, rd_en, s1_valid, we;
  logic [CW-1:0]           rd_addr, s1_col, waddr;
  logic signed [SUM_W-1:0] rd_data, wdata;
  stage_t                  s1;

  tmps_sched #(
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_sched (
    .clk      (clk),
    .rst      (rst),
    .valid    (entry.valid),
    .value    (entry.value),
    .last     (entry.last),
    .advance  (advance),
    .ready    (entry.ready),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_col   (s1_col)
  );

  tmps_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (CW)
  ) u_row_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tmps_update #(
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_col    (s1_col),
    .rd_data   (rd_data),
    .out_ready (result.ready),
    .advance   (advance),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .out_valid (result.valid),
    .min_total (result.min_total),
    .status    (result.status)
  );

endmodule

`default_nettype wire
